// ===== hw/rtl/fejs_pkg.sv =====
// shared types and constants of the first-edge fetch and join stage
`timescale 1ns / 1ps

package fejs_pkg;

    localparam int WORD_W = 32;
    localparam int ADDR_W = 12;

    localparam int FULL_LEVEL_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int ID_WIDTH_DEF    = 20;

    // command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // control bits of one classified request
    typedef struct packed {
        logic is_write;
        logic clear;
        logic read_valid;
        logic iter_end;
        logic iter_valid;
        logic ds_full;
        logic addr_ok;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

endpackage

// ===== hw/rtl/fejs_cmd_fifo.sv =====
// small command queue that decouples the front from the back
`timescale 1ns / 1ps

module fejs_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic                         o_valid,
    output logic [WIDTH-1:0]             o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_head, n_head;
    logic [PW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_head  = i_pop  ? wrap_inc(r_head) : r_head;
        n_tail  = i_push ? wrap_inc(r_tail) : r_tail;
        n_count = r_count + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_head];
    assign o_count = r_count;

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && 32'(r_count) == DEPTH))
        else $error("command queue overflow");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == '0))
        else $error("command queue underflow");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("command queue count mismatch");

endmodule

// ===== hw/rtl/fejs_queue.sv =====
// circular data queue with a registered head read
`timescale 1ns / 1ps

module fejs_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_push_data,
    input  logic                         i_pop,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output logic [WIDTH-1:0]             o_head_q
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_head_q;
    logic [PW-1:0]    r_head, n_head;
    logic [PW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        if (i_clear) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end else begin
            n_head  = i_pop  ? wrap_inc(r_head) : r_head;
            n_tail  = i_push ? wrap_inc(r_tail) : r_tail;
            n_count = r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // storage: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (i_push && !i_clear) begin
            r_mem[r_tail] <= i_push_data;
        end
        if (i_pop && !i_clear) begin
            r_head_q <= r_mem[r_head];
        end
    end

    assign o_count  = r_count;
    assign o_head_q = r_head_q;

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && 32'(r_count) == DEPTH))
        else $error("data queue pushed while full");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == '0))
        else $error("data queue popped while empty");

endmodule

// ===== hw/rtl/fejs_front.sv =====
// front part: request intake, classification and first-edge table access
`timescale 1ns / 1ps

module fejs_front #(
    parameter int TABLE_DEPTH = fejs_pkg::TABLE_DEPTH_DEF,
    parameter int ID_WIDTH    = fejs_pkg::ID_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_operation,
    input  logic                            i_clear,
    input  logic                            i_push_flag_in,
    input  logic [ID_WIDTH-1:0]             i_vertex_id_in,
    input  logic [fejs_pkg::WORD_W-1:0]     i_vertex_value_in,
    input  logic                            i_read_valid,
    input  logic [fejs_pkg::ADDR_W-1:0]     i_table_address,
    input  logic [fejs_pkg::WORD_W-1:0]     i_table_write_data,
    input  logic                            i_iteration_end_in,
    input  logic                            i_iteration_end_valid_in,
    input  logic                            i_downstream_full,
    input  logic [fejs_pkg::CMD_CNT_W-1:0]  i_cmd_count,
    output logic                            o_cmd_valid,
    output fejs_pkg::t_ctl                  o_ctl,
    output logic                            o_flag,
    output logic [ID_WIDTH-1:0]             o_id,
    output logic [fejs_pkg::WORD_W-1:0]     o_value,
    output logic [fejs_pkg::WORD_W-1:0]     o_word
);
    import fejs_pkg::*;

    localparam int TW = $clog2(TABLE_DEPTH);

    logic [WORD_W-1:0] r_table [TABLE_DEPTH];
    logic [WORD_W-1:0] r_table_q;
    logic              r_a_valid;
    t_ctl              r_a_ctl;
    logic              r_a_flag;
    logic [ID_WIDTH-1:0] r_a_id;
    logic [WORD_W-1:0] r_a_value;

    logic              w_accept;
    logic [31:0]       w_addr_ext;
    logic [TW-1:0]     w_idx;
    logic              w_addr_ok;
    t_ctl              w_ctl;

    // credit check: queued commands plus the one in flight
    assign o_ready  = (32'(i_cmd_count) + 32'(r_a_valid)) < CMD_DEPTH;
    assign w_accept = i_valid && o_ready;

    assign w_addr_ext = 32'(i_table_address);
    assign w_idx      = w_addr_ext[TW-1:0];
    assign w_addr_ok  = w_addr_ext < TABLE_DEPTH;

    always_comb begin
        w_ctl.is_write   = (i_operation == OP_WRITE);
        w_ctl.clear      = i_clear;
        w_ctl.read_valid = i_read_valid;
        w_ctl.iter_end   = i_iteration_end_in;
        w_ctl.iter_valid = i_iteration_end_valid_in;
        w_ctl.ds_full    = i_downstream_full;
        w_ctl.addr_ok    = w_addr_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_ctl   <= w_ctl;
            r_a_flag  <= i_push_flag_in;
            r_a_id    <= i_vertex_id_in;
            r_a_value <= i_vertex_value_in;
        end
    end

    // table memory: at most one access per accepted request
    always_ff @(posedge i_clk) begin
        if (w_accept && w_ctl.is_write && w_addr_ok) begin
            r_table[w_idx] <= i_table_write_data;
        end
        if (w_accept && !w_ctl.is_write) begin
            r_table_q <= r_table[w_idx];
        end
    end

    assign o_cmd_valid = r_a_valid;
    assign o_ctl       = r_a_ctl;
    assign o_flag      = r_a_flag;
    assign o_id        = r_a_id;
    assign o_value     = r_a_value;
    assign o_word      = r_a_ctl.addr_ok ? r_table_q : '0;

endmodule

// ===== hw/rtl/fejs_back.sv =====
// back part: vertex and edge queues, join and result register
`timescale 1ns / 1ps

module fejs_back #(
    parameter int FULL_LEVEL  = fejs_pkg::FULL_LEVEL_DEF,
    parameter int QUEUE_DEPTH = fejs_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = fejs_pkg::ID_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  fejs_pkg::t_ctl                i_ctl,
    input  logic                          i_flag,
    input  logic [ID_WIDTH-1:0]           i_id,
    input  logic [fejs_pkg::WORD_W-1:0]   i_value,
    input  logic [fejs_pkg::WORD_W-1:0]   i_word,
    output logic                          o_cmd_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_stage_full,
    output logic                          o_push_flag_out,
    output logic [ID_WIDTH-1:0]           o_vertex_id_out,
    output logic [fejs_pkg::WORD_W-1:0]   o_vertex_value_out,
    output logic [fejs_pkg::WORD_W-1:0]   o_first_edge_out,
    output logic                          o_out_valid,
    output logic                          o_iteration_end_out
);
    import fejs_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int VW = 1 + ID_WIDTH + WORD_W;

    logic              r_res_valid;
    logic              r_res_full;
    logic              r_res_pop;
    logic              r_res_iter;
    logic              r_pend_valid;
    logic [WORD_W-1:0] r_pend_word;

    logic [CW-1:0]     w_vcnt, w_ecnt;
    logic [VW-1:0]     w_vhead;
    logic [WORD_W-1:0] w_ehead;
    logic              w_exec, w_tick, w_clr;
    logic              w_vpush, w_epush, w_pop, w_iter;
    logic              w_vempty, w_eempty;
    logic [31:0]       w_vcnt_next;
    logic              w_full;

    assign w_exec   = i_cmd_valid && (!r_res_valid || i_ready);
    assign w_tick   = w_exec && !i_ctl.is_write;
    assign w_clr    = w_tick && i_ctl.clear;
    assign w_vempty = (w_vcnt == '0);
    assign w_eempty = (w_ecnt == '0);

    assign w_vpush = w_tick && !i_ctl.clear && i_ctl.read_valid
                   && (32'(w_vcnt) < QUEUE_DEPTH);
    assign w_epush = w_tick && !i_ctl.clear && r_pend_valid
                   && (32'(w_ecnt) < QUEUE_DEPTH);
    assign w_pop   = w_tick && !i_ctl.clear && !i_ctl.ds_full && !w_vempty && !w_eempty;
    assign w_iter  = w_tick && !i_ctl.clear && i_ctl.iter_end && i_ctl.iter_valid
                   && w_vempty && !i_ctl.read_valid;

    assign w_vcnt_next = 32'(w_vcnt) + 32'(w_vpush) - 32'(w_pop);
    assign w_full      = !w_clr && (w_vcnt_next >= FULL_LEVEL);

    fejs_queue #(
        .WIDTH (VW),
        .DEPTH (QUEUE_DEPTH)
    ) u_vertex_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_clr),
        .i_push      (w_vpush),
        .i_push_data ({i_flag, i_id, i_value}),
        .i_pop       (w_pop),
        .o_count     (w_vcnt),
        .o_head_q    (w_vhead)
    );

    fejs_queue #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_edge_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_clr),
        .i_push      (w_epush),
        .i_push_data (r_pend_word),
        .i_pop       (w_pop),
        .o_count     (w_ecnt),
        .o_head_q    (w_ehead)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid  <= 1'b0;
            r_res_full   <= 1'b0;
            r_res_pop    <= 1'b0;
            r_res_iter   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend_word  <= '0;
        end else begin
            if (w_exec) begin
                r_res_valid <= 1'b1;
                r_res_full  <= w_full;
                r_res_pop   <= w_pop;
                r_res_iter  <= w_iter;
            end else if (i_ready) begin
                r_res_valid <= 1'b0;
            end
            // table word fetched by this tick joins the edge queue on the next tick
            if (w_tick) begin
                r_pend_valid <= !i_ctl.clear && i_ctl.read_valid;
                r_pend_word  <= i_word;
            end
        end
    end

    assign o_cmd_pop           = w_exec;
    assign o_valid             = r_res_valid;
    assign o_stage_full        = r_res_full;
    assign o_out_valid         = r_res_pop;
    assign o_iteration_end_out = r_res_iter;
    assign o_push_flag_out     = r_res_pop ? w_vhead[VW-1] : 1'b0;
    assign o_vertex_id_out     = r_res_pop ? w_vhead[VW-2 -: ID_WIDTH] : '0;
    assign o_vertex_value_out  = r_res_pop ? w_vhead[WORD_W-1:0] : '0;
    assign o_first_edge_out    = r_res_pop ? w_ehead : '0;

endmodule

// ===== hw/rtl/first_edge_fetch_join_stage_core.sv =====
// top level of the first-edge fetch and join stage
`timescale 1ns / 1ps

// One request per clock is taken at the input handshake while the command queue
// has room, and one result leaves per request, in order. A request is either a
// table write (operation high), which only stores a word in the first-edge table
// and returns the current full flag, or a tick, which queues the incoming vertex,
// reads the table, pushes the word read by the previous tick into the edge queue,
// joins the two queue heads when both held data and downstream is not full, and
// forwards an iteration end when the vertex queue was empty and no vertex arrived;
// a tick with clear set empties both queues instead. The sustained rate is one
// request per cycle while the output is not stalled; a request is registered in
// the front, where the table is read, then passes through the command queue to its
// head, where the back updates the queues and loads the result register. A four-entry
// command queue separates the two halves, so a stalled output keeps accepting
// until that queue fills. No clearing pass runs after reset: the table and the
// queue storage are undefined until written, and the block is ready at once.
module first_edge_fetch_join_stage_core #(
    parameter int FULL_LEVEL  = fejs_pkg::FULL_LEVEL_DEF,
    parameter int QUEUE_DEPTH = fejs_pkg::QUEUE_DEPTH_DEF,
    parameter int TABLE_DEPTH = fejs_pkg::TABLE_DEPTH_DEF,
    parameter int ID_WIDTH    = fejs_pkg::ID_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_operation,
    input  logic                                i_clear,
    input  logic                                i_push_flag_in,
    input  logic [ID_WIDTH-1:0]                 i_vertex_id_in,
    input  logic signed [fejs_pkg::WORD_W-1:0]  i_vertex_value_in,
    input  logic                                i_read_valid,
    input  logic [fejs_pkg::ADDR_W-1:0]         i_table_address,
    input  logic signed [fejs_pkg::WORD_W-1:0]  i_table_write_data,
    input  logic                                i_iteration_end_in,
    input  logic                                i_iteration_end_valid_in,
    input  logic                                i_downstream_full,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_stage_full,
    output logic                                o_push_flag_out,
    output logic [ID_WIDTH-1:0]                 o_vertex_id_out,
    output logic signed [fejs_pkg::WORD_W-1:0]  o_vertex_value_out,
    output logic signed [fejs_pkg::WORD_W-1:0]  o_first_edge_out,
    output logic                                o_out_valid,
    output logic                                o_iteration_end_out
);
    import fejs_pkg::*;

    // command word: control bits, vertex flag, id, value, fetched table word
    localparam int CMD_W = CTL_W + 1 + ID_WIDTH + 2 * WORD_W;

    logic                  w_f_valid;
    t_ctl                  w_f_ctl;
    logic                  w_f_flag;
    logic [ID_WIDTH-1:0]   w_f_id;
    logic [WORD_W-1:0]     w_f_value;
    logic [WORD_W-1:0]     w_f_word;

    logic [CMD_W-1:0]      w_q_data;
    logic                  w_q_valid;
    logic [CMD_CNT_W-1:0]  w_q_count;
    logic                  w_q_pop;

    t_ctl                  w_b_ctl;
    logic                  w_b_flag;
    logic [ID_WIDTH-1:0]   w_b_id;
    logic [WORD_W-1:0]     w_b_value;
    logic [WORD_W-1:0]     w_b_word;

    logic [WORD_W-1:0]     w_vval_out;
    logic [WORD_W-1:0]     w_edge_out;

    // front: takes requests, classifies them and accesses the table
    fejs_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_front (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_valid                  (i_valid),
        .o_ready                  (o_ready),
        .i_operation              (i_operation),
        .i_clear                  (i_clear),
        .i_push_flag_in           (i_push_flag_in),
        .i_vertex_id_in           (i_vertex_id_in),
        .i_vertex_value_in        (i_vertex_value_in),
        .i_read_valid             (i_read_valid),
        .i_table_address          (i_table_address),
        .i_table_write_data       (i_table_write_data),
        .i_iteration_end_in       (i_iteration_end_in),
        .i_iteration_end_valid_in (i_iteration_end_valid_in),
        .i_downstream_full        (i_downstream_full),
        .i_cmd_count              (w_q_count),
        .o_cmd_valid              (w_f_valid),
        .o_ctl                    (w_f_ctl),
        .o_flag                   (w_f_flag),
        .o_id                     (w_f_id),
        .o_value                  (w_f_value),
        .o_word                   (w_f_word)
    );

    // decoupling queue: front never stalls, credit is checked at intake
    fejs_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_data  ({w_f_ctl, w_f_flag, w_f_id, w_f_value, w_f_word}),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .o_count (w_q_count)
    );

    // unpack the head command for the back
    assign w_b_ctl   = t_ctl'(w_q_data[CMD_W-1 -: CTL_W]);
    assign w_b_flag  = w_q_data[CMD_W-CTL_W-1];
    assign w_b_id    = w_q_data[2*WORD_W +: ID_WIDTH];
    assign w_b_value = w_q_data[WORD_W +: WORD_W];
    assign w_b_word  = w_q_data[WORD_W-1:0];

    // back: queue updates, join and result register
    fejs_back #(
        .FULL_LEVEL  (FULL_LEVEL),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd_valid         (w_q_valid),
        .i_ctl               (w_b_ctl),
        .i_flag              (w_b_flag),
        .i_id                (w_b_id),
        .i_value             (w_b_value),
        .i_word              (w_b_word),
        .o_cmd_pop           (w_q_pop),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_stage_full        (o_stage_full),
        .o_push_flag_out     (o_push_flag_out),
        .o_vertex_id_out     (o_vertex_id_out),
        .o_vertex_value_out  (w_vval_out),
        .o_first_edge_out    (w_edge_out),
        .o_out_valid         (o_out_valid),
        .o_iteration_end_out (o_iteration_end_out)
    );

    assign o_vertex_value_out = signed'(w_vval_out);
    assign o_first_edge_out   = signed'(w_edge_out);

endmodule
